// File: rtl/sorted_key_binary_search_top_macros.svh
// Assertion macros shared by the sorted-key search RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef SORTED_KEY_BINARY_SEARCH_TOP_MACROS_SVH
`define SORTED_KEY_BINARY_SEARCH_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising clock edge outside reset
`define SKBS_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included
`define SKBS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define SKBS_ASSERT_RST(lbl, clk, rst, prop, msg)
`define SKBS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: rtl/skbs_pkg.sv
// Shared types and constants of the sorted-key search block.
// No dependencies; imported by the top, compare and sequencer modules of the block.
package skbs_pkg;

   // Fixed field widths
   localparam int CNT_W = 11;
   localparam int IDX_W = 10;
   localparam int KEY_PORT_W = 64;

   // Request command codes
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_CHECK,
      ST_DONE
   } state_type;

   // Sequencer to datapath controls
   typedef struct packed {
      logic ready;
      logic write_en;
      logic load;
      logic probe;
      logic check;
      logic emit;
   } ctl_type;

   // Datapath to sequencer status
   typedef struct packed {
      logic empty;
      logic hit;
      logic converge;
      logic out_free;
   } sts_type;

   // Key compare result: probe equal to / below the search key
   typedef struct packed {
      logic eq;
      logic lt;
   } cmp_type;

endpackage

// File: rtl/sorted_key_binary_search_top.sv
// Top level of the sorted-key search block: bounds, key table and result register.
// Depends on skbs_pkg, skbs_ram, skbs_cmp, skbs_ctrl and the assertion macro header.
//
// Usage:
//   req_* carries one item per transfer (req_valid high, req_stall low).
//   A write item (command 0) stores search_key at entry_index
//   and gives no result. A search item (command 1) runs a binary search over
//   the first entries_in_use entries and gives one rsp_* transfer with the
//   found flag and the matching index (0 when not found).
//   csr_write_en / csr_write_data load entries_in_use; write it while idle.
// Search steps:
//   Each probe is one table read in ST_PROBE, then one compare in ST_CHECK
//   of the data from the single registered read port of the key table. A
//   search makes at most ceil(log2(n+1)) probes for n entries in use; an
//   empty table answers without a probe. req_stall is high while a search runs.
// Reset and stall:
//   Reset clears the sequencer, the output valid flag and entries_in_use; the
//   table keeps its contents and needs loading before use. A stalled result
//   holds in the output register; a new item is still taken meanwhile, and
//   the next search waits at its end until the register frees up.
`include "sorted_key_binary_search_top_macros.svh"

module sorted_key_binary_search_top import skbs_pkg::*; #(
   parameter int TABLE_DEPTH = 1024,
   parameter int KEY_BYTES   = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CNT_W-1:0]      csr_write_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_command,
   input  logic [IDX_W-1:0]      req_entry_index,
   input  logic [KEY_PORT_W-1:0] req_search_key,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_found,
   output logic [IDX_W-1:0]      rsp_match_index
);

   localparam int KEY_W = KEY_BYTES * 8;
   localparam int AW    = $clog2(TABLE_DEPTH);
   localparam int BW    = $clog2(TABLE_DEPTH + 1);
   localparam int SW    = (BW > CNT_W) ? BW : CNT_W;

   ctl_type ctl;
   sts_type sts;
   cmp_type cmp;

   logic [CNT_W-1:0] entries_ff;
   logic [BW-1:0]    lo_ff;
   logic [BW-1:0]    hp1_ff;
   logic [AW-1:0]    mid_ff;
   logic [KEY_W-1:0] key_ff;
   logic             hit_ff;
   logic             rsp_valid_ff;
   logic             rsp_found_ff;
   logic [IDX_W-1:0] rsp_index_ff;

   logic [SW-1:0]    count_wide;
   logic [SW-1:0]    count_clamp;
   logic [BW-1:0]    hp1_init;
   logic             wr_in_range;
   logic [BW:0]      mid_sum;
   logic [AW-1:0]    mid_c;
   logic [BW-1:0]    lo_in;
   logic [BW-1:0]    hp1_in;
   logic [KEY_W-1:0] probe_key;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= '0;
      end else if (csr_write_en) begin
         entries_ff <= csr_write_data;
      end
   end

   // Clamp the entry count to the table depth; the upper bound is kept exclusive
   always_comb begin
      count_wide  = SW'(entries_ff);
      count_clamp = (count_wide > SW'(TABLE_DEPTH)) ? SW'(TABLE_DEPTH) : count_wide;
      hp1_init    = BW'(count_clamp);
      wr_in_range = SW'(req_entry_index) < SW'(TABLE_DEPTH);
   end

   // Midpoint of the live range (lo + hi) / 2 with hi = hp1 - 1
   always_comb begin
      mid_sum = {1'b0, lo_ff} + {1'b0, hp1_ff} - (BW + 1)'(1);
      mid_c   = AW'(mid_sum >> 1);
   end

   // Key table
   skbs_ram #(
      .WIDTH (KEY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_key_table (
      .clock   (clock),
      .wr_en   (ctl.write_en && wr_in_range),
      .wr_addr (AW'(req_entry_index)),
      .wr_data (req_search_key[KEY_W-1:0]),
      .rd_en   (ctl.probe),
      .rd_addr (mid_c),
      .rd_data (probe_key)
   );

   // Shared compare unit
   skbs_cmp #(
      .KEY_W (KEY_W)
   ) u_cmp (
      .probe_key  (probe_key),
      .search_key (key_ff),
      .result     (cmp)
   );

   // Move one bound past the midpoint
   always_comb begin
      if (cmp.lt) begin
         lo_in  = BW'(mid_ff) + BW'(1);
         hp1_in = hp1_ff;
      end else begin
         lo_in  = lo_ff;
         hp1_in = BW'(mid_ff);
      end
   end

   // Status toward the sequencer
   always_comb begin
      sts.empty    = (hp1_init == '0);
      sts.hit      = cmp.eq;
      sts.converge = (lo_in >= hp1_in);
      sts.out_free = !rsp_valid_ff || !rsp_stall;
   end

   // Search datapath registers
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         lo_ff  <= '0;
         hp1_ff <= hp1_init;
         key_ff <= req_search_key[KEY_W-1:0];
         hit_ff <= 1'b0;
      end else if (ctl.check) begin
         hit_ff <= cmp.eq;
         if (!cmp.eq) begin
            lo_ff  <= lo_in;
            hp1_ff <= hp1_in;
         end
      end
      if (ctl.probe) begin
         mid_ff <= mid_c;
      end
   end

   // Sequencer
   skbs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .sts         (sts),
      .ctl         (ctl)
   );

   assign req_stall = !ctl.ready;

   // Output register: load on emit, drop on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.emit) begin
         rsp_found_ff <= hit_ff;
         rsp_index_ff <= hit_ff ? IDX_W'(mid_ff) : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_match_index = rsp_index_ff;

   // A table read only happens over a non-empty range
   `SKBS_ASSERT_RST(a_probe_range, clock, reset,
      ctl.probe |-> (lo_ff < hp1_ff),
      "table read over an empty search range")

   // A miss always reports index zero
   `SKBS_ASSERT_RST(a_miss_index, clock, reset,
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_index_ff == '0),
      "miss reported with a nonzero index")

endmodule

// File: rtl/skbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the key table of the search block.
module skbs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/skbs_cmp.sv
// Shared key compare unit: unsigned magnitude compare of probe and key.
// Depends on skbs_pkg for the compare result type.
module skbs_cmp import skbs_pkg::*; #(
   parameter int KEY_W = 64
) (
   input  logic [KEY_W-1:0] probe_key,
   input  logic [KEY_W-1:0] search_key,
   output cmp_type          result
);

   // Compare packed bytes, top byte first, as unsigned words
   always_comb begin
      result.eq = (probe_key == search_key);
      result.lt = (probe_key < search_key);
   end

endmodule

// File: rtl/skbs_ctrl.sv
// Sequencer of the sorted-key search: accepts items and steps the probes.
// Depends on skbs_pkg and the assertion macro header.
`include "sorted_key_binary_search_top_macros.svh"

module skbs_ctrl import skbs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_command,
   input  sts_type sts,
   output ctl_type ctl
);

   state_type state_ff;
   state_type state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_command == CMD_SEARCH)) begin
               state_in = sts.empty ? ST_DONE : ST_PROBE;
            end
         end
         ST_PROBE: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = (sts.hit || sts.converge) ? ST_DONE : ST_PROBE;
         end
         ST_DONE: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control outputs
   always_comb begin
      ctl          = '0;
      ctl.ready    = (state_ff == ST_IDLE);
      ctl.write_en = (state_ff == ST_IDLE) && req_valid && (req_command == CMD_WRITE);
      ctl.load     = (state_ff == ST_IDLE) && req_valid && (req_command == CMD_SEARCH);
      ctl.probe    = (state_ff == ST_PROBE);
      ctl.check    = (state_ff == ST_CHECK);
      ctl.emit     = (state_ff == ST_DONE) && sts.out_free;
   end

   // A compare always follows the read it consumes
   `SKBS_ASSERT_RST(a_check_after_probe, clock, reset,
      (state_ff == ST_CHECK) |-> ($past(state_ff) == ST_PROBE),
      "compare without a preceding table read")

   // A result is only issued into a free output register
   `SKBS_ASSERT_RST(a_emit_free, clock, reset,
      ctl.emit |-> sts.out_free,
      "result issued while output register is occupied")

endmodule
